// ----- rtl/sdi12_pkg.sv -----
// Shared types, codes and constants of the SDI-12 reply parser.
package sdi12_pkg;

  // Input operation codes, carried in s_tuser.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Failure codes.
  localparam logic [2:0] FC_NONE        = 3'd0;
  localparam logic [2:0] FC_NO_ADDRESS  = 3'd1;
  localparam logic [2:0] FC_WRONG_ADDR  = 3'd2;
  localparam logic [2:0] FC_TIMEOUT     = 3'd3;
  localparam logic [2:0] FC_BAD_TRAILER = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_SENSOR_ADDRESS = 3'd0;
  localparam logic [2:0] REG_SKIP_COUNT     = 3'd1;
  localparam logic [2:0] REG_STOP_BYTE      = 3'd2;
  localparam logic [2:0] REG_TIMEOUT_LIMIT  = 3'd3;
  localparam logic [2:0] REG_EXPECTED_LEN   = 3'd4;
  localparam logic [2:0] REG_COMMAND_LEN    = 3'd5;
  localparam logic [2:0] REG_TRIM_MODE      = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Timing constants in milliseconds.
  localparam int TICK_MS     = 9;
  localparam int ELAPSED_W   = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [ELAPSED_W-1:0] WAIT_BASE_MS = 17'd12;

  // Character constants.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ADDR = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  // Live configuration seen by the parser.
  typedef struct packed {
    logic [6:0]  sensor_address;
    logic [7:0]  skip_count;
    logic [7:0]  stop_byte;
    logic [15:0] timeout_limit;
    logic [7:0]  expected_len;
    logic [2:0]  command_len;
    logic        trim_mode;
  } cfg_t;

  // One result of the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] out_char;
    logic [1:0] status;
    logic [2:0] fail_code;
    logic       last;
  } res_t;

endpackage

// ----- rtl/sdi12_cfg.sv -----
// Configuration register file of the SDI-12 reply parser.
module sdi12_cfg
  import sdi12_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_address <= 7'd48;
      cfg.skip_count     <= 8'd0;
      cfg.stop_byte      <= 8'd13;
      cfg.timeout_limit  <= 16'd1000;
      cfg.expected_len   <= 8'd35;
      cfg.command_len    <= 3'd4;
      cfg.trim_mode      <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SENSOR_ADDRESS: cfg.sensor_address <= wr_data[6:0];
        REG_SKIP_COUNT:     cfg.skip_count     <= wr_data[7:0];
        REG_STOP_BYTE:      cfg.stop_byte      <= wr_data[7:0];
        REG_TIMEOUT_LIMIT:  cfg.timeout_limit  <= wr_data[15:0];
        REG_EXPECTED_LEN:   cfg.expected_len   <= wr_data[7:0];
        REG_COMMAND_LEN:    cfg.command_len    <= wr_data[2:0];
        REG_TRIM_MODE:      cfg.trim_mode      <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/sdi12_parse.sv -----
// Reply parsing state and the per-item next-state and result logic.
module sdi12_parse
  import sdi12_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  phase_t                phase, phase_next;
  logic [7:0]            skip_left, skip_left_next;
  logic                  append_on, append_on_next;
  logic [ELAPSED_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic [7:0]            held0, held0_next;
  logic [7:0]            held1, held1_next;
  logic [1:0]            held_count, held_count_next;

  logic [ELAPSED_W-1:0]  wait_preset;
  logic [ELAPSED_W:0]    tick_sum;
  logic [ELAPSED_W-1:0]  tick_sat;
  logic                  appending;

  // Initial wait estimate: 12 + 8 * command_len + 8 * expected_len.
  assign wait_preset = WAIT_BASE_MS
                     + {11'd0, cfg.command_len, 3'd0}
                     + {6'd0, cfg.expected_len, 3'd0};
  assign tick_sum = {1'b0, elapsed_ms} + (ELAPSED_W+1)'(TICK_MS);
  assign tick_sat = tick_sum[ELAPSED_W] ? ELAPSED_MAX : tick_sum[ELAPSED_W-1:0];
  // The stop byte itself is not appended, and appending stays off afterward.
  assign appending = append_on && (rx_byte != cfg.stop_byte);

  always_comb begin
    phase_next      = phase;
    skip_left_next  = skip_left;
    append_on_next  = append_on;
    elapsed_ms_next = elapsed_ms;
    held0_next      = held0;
    held1_next      = held1;
    held_count_next = held_count;
    res             = '0;

    if (op == OP_START) begin
      skip_left_next  = cfg.skip_count;
      append_on_next  = 1'b1;
      held_count_next = 2'd0;
      elapsed_ms_next = wait_preset;
      if (cfg.sensor_address == 7'd0) begin
        phase_next    = PH_IDLE;
        res.valid     = 1'b1;
        res.status    = ST_FAIL;
        res.fail_code = FC_NO_ADDRESS;
        res.last      = 1'b1;
      end else begin
        phase_next = PH_ADDR;
      end
    end else if (phase != PH_IDLE && op == OP_TICK) begin
      elapsed_ms_next = tick_sat;
      if (tick_sat > {1'b0, cfg.timeout_limit}) begin
        phase_next    = PH_IDLE;
        res.valid     = 1'b1;
        res.status    = ST_FAIL;
        res.fail_code = FC_TIMEOUT;
        res.last      = 1'b1;
      end
    end else if (phase == PH_ADDR && op == OP_BYTE) begin
      if (rx_byte != {1'b0, cfg.sensor_address}) begin
        phase_next    = PH_IDLE;
        res.valid     = 1'b1;
        res.status    = ST_FAIL;
        res.fail_code = FC_WRONG_ADDR;
        res.last      = 1'b1;
      end else begin
        phase_next = PH_BODY;
      end
    end else if (phase == PH_BODY && op == OP_BYTE) begin
      if (rx_byte == CH_LF) begin
        phase_next = PH_IDLE;
        res.valid  = 1'b1;
        res.last   = 1'b1;
        if (cfg.trim_mode && (held_count != 2'd2 || held1 != CH_ZERO)) begin
          res.status    = ST_FAIL;
          res.fail_code = FC_BAD_TRAILER;
        end else begin
          res.status = ST_OK;
        end
      end else if (skip_left != 8'd0) begin
        skip_left_next = skip_left - 8'd1;
      end else begin
        append_on_next = appending;
        if (appending) begin
          if (!cfg.trim_mode) begin
            res.valid    = 1'b1;
            res.out_char = rx_byte;
            res.status   = ST_DATA;
          end else if (held_count == 2'd0) begin
            held0_next      = rx_byte;
            held_count_next = 2'd1;
          end else if (held_count == 2'd1) begin
            held1_next      = rx_byte;
            held_count_next = 2'd2;
          end else begin
            // Two bytes are held back; the oldest one leaves.
            held0_next   = held1;
            held1_next   = rx_byte;
            res.valid    = 1'b1;
            res.out_char = (held0 == CH_SPACE) ? CH_TAB : held0;
            res.status   = ST_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      skip_left  <= 8'd0;
      append_on  <= 1'b1;
      elapsed_ms <= '0;
      held_count <= 2'd0;
    end else if (step) begin
      phase      <= phase_next;
      skip_left  <= skip_left_next;
      append_on  <= append_on_next;
      elapsed_ms <= elapsed_ms_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

`ifndef SYNTH
  a_final_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.last |=> phase == PH_IDLE)
    else $error("parser did not return to idle after a final result");

  a_fail_has_code: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_FAIL |-> res.fail_code != FC_NONE && res.last)
    else $error("failure result without a failure code");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("more than two bytes held back");
`endif

endmodule

// ----- rtl/sdi12_reply_parser.sv -----
// Top level of the SDI-12 reply parser: stream ports, input and result registers.
//
// The parser follows one SDI-12 sensor reply, one transaction at a time. Each
// input transaction carries an operation in s_tuser (start of a new reply, a
// received byte in s_tdata, or a 9 ms idle tick) and produces zero or one
// result transaction: a reply data byte, a successful end of reply, or a
// failure with its reason. A start transaction presets the elapsed wait to
// 12 + 8 * command_len + 8 * expected_len ms and fails at once when no sensor
// address is configured; ticks add 9 ms and fail the reply once the wait
// exceeds timeout_limit. The first received byte must be the sensor address,
// skip_count bytes after it are dropped, the stop byte ends appending, and a
// line feed ends the reply. In trim mode the last two appended bytes are held
// back and dropped, the final one must be '0', and spaces are sent as tabs.
// Each transaction is taken into an input register and then worked on by
// combinational logic that writes the result register, so one transaction
// is accepted per clock while the result register is not held by m_tready.
// The input register keeps taking work while a result waits in the output
// register; s_tready drops only when both registers are full and m_tready is
// low. Configuration registers are written through the cfg channel, which is
// always ready, and should only be changed while no reply transaction is in
// flight.
module sdi12_reply_parser
  import sdi12_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] rx_byte
  input  logic [1:0]             s_tuser,   // [1:0] op
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // [7:0] out_char
  output logic [4:0]             m_tuser,   // [1:0] status, [4:2] fail_code
  output logic                   m_tlast,   // last
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  res_t       res;
  logic       in_valid;
  logic [1:0] in_op;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;

  assign cfg_ready = 1'b1;

  sdi12_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The stage moves when the result register is empty or being drained.
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  sdi12_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .op      (in_op),
    .rx_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      m_tdata <= res.out_char;
      m_tuser <= {res.fail_code, res.status};
      m_tlast <= res.last;
    end
  end

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled while a register was free");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_op) && $stable(in_byte))
    else $error("pending input transaction lost during a stall");
`endif

endmodule
